>>> rtl/core/touch_gesture_decoder_macros.svh
// Assertion helpers shared by the gesture decoder modules.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef TOUCH_GESTURE_DECODER_MACROS_SVH
`define TOUCH_GESTURE_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TGD_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TGD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tgd_pkg.sv
package tgd_pkg;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int TAP_W     = 3;

	localparam logic [TAP_W-1:0] TAP_MAX = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_FEED_HOLD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_HOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TAP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_GAP     = 3'd3;

	localparam logic [CFG_W-1:0] FEED_HOLD_RESET   = 16'd350;
	localparam logic [CFG_W-1:0] TOGGLE_HOLD_RESET = 16'd1200;
	localparam logic [CFG_W-1:0] MIN_TAP_RESET     = 16'd10;
	localparam logic [CFG_W-1:0] TAP_GAP_RESET     = 16'd400;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_LID_OPEN  = 3'd1,
		EV_LID_CLOSE = 3'd2,
		EV_OFFLINE   = 3'd3,
		EV_HISTORY   = 3'd4
	} gesture_t;

	typedef struct packed {
		logic [CFG_W-1:0] feed_hold_ticks;
		logic [CFG_W-1:0] toggle_hold_ticks;
		logic [CFG_W-1:0] min_tap_ticks;
		logic [CFG_W-1:0] tap_gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
	} cfg_wr_t;

	typedef struct packed {
		gesture_t gesture_event;
		logic     offline_flag;
		logic     lid_flag;
	} result_t;

endpackage

>>> rtl/core/tgd_cfg.sv
module tgd_cfg (
	input  logic           clk,
	input  logic           arst_n,
	input  tgd_pkg::cfg_wr_t wr,
	output tgd_pkg::cfg_t  cfg
);
	import tgd_pkg::*;

	cfg_t cfg_q;

	// Writes to an index outside the register list fall through and are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.feed_hold_ticks   <= FEED_HOLD_RESET;
			cfg_q.toggle_hold_ticks <= TOGGLE_HOLD_RESET;
			cfg_q.min_tap_ticks     <= MIN_TAP_RESET;
			cfg_q.tap_gap_ticks     <= TAP_GAP_RESET;
		end else if (wr.valid) begin
			unique case (wr.index)
				REG_FEED_HOLD:   cfg_q.feed_hold_ticks   <= wr.data;
				REG_TOGGLE_HOLD: cfg_q.toggle_hold_ticks <= wr.data;
				REG_MIN_TAP:     cfg_q.min_tap_ticks     <= wr.data;
				REG_TAP_GAP:     cfg_q.tap_gap_ticks     <= wr.data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/tgd_core.sv
module tgd_core #(
	parameter int COUNTER_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             touch,
	input  tgd_pkg::cfg_t    cfg,
	output tgd_pkg::result_t result
);
	import tgd_pkg::*;
	`include "touch_gesture_decoder_macros.svh"

	// Width at which counters and thresholds are compared.
	localparam int CMP_W = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;

	localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

	logic                    prev_touch_q;
	logic [COUNTER_BITS-1:0] press_ticks_q;
	logic [COUNTER_BITS-1:0] since_tap_ticks_q;
	logic [TAP_W-1:0]        taps_seen_q;
	logic                    tap_locked_q;
	logic                    lid_is_open_q;
	logic                    offline_mode_q;

	logic [COUNTER_BITS-1:0] press_d;
	logic [COUNTER_BITS-1:0] since_d;
	logic [COUNTER_BITS-1:0] press_inc;
	logic [TAP_W-1:0]        taps_d;
	logic                    locked_d;
	logic                    lid_d;
	logic                    offline_d;
	gesture_t                event_d;

	assign press_inc = (press_ticks_q == CNT_MAX) ? CNT_MAX : press_ticks_q + 1'b1;

	always_comb begin
		event_d   = EV_NONE;
		press_d   = press_ticks_q;
		taps_d    = taps_seen_q;
		locked_d  = tap_locked_q;
		lid_d     = lid_is_open_q;
		offline_d = offline_mode_q;
		since_d   = (since_tap_ticks_q == CNT_MAX) ? CNT_MAX : since_tap_ticks_q + 1'b1;

		if (touch) begin
			press_d = prev_touch_q ? press_inc : '0;
			if (!locked_d && taps_d == 3'd1 && !lid_d &&
			    CMP_W'(press_d) > CMP_W'(cfg.toggle_hold_ticks)) begin
				offline_d = ~offline_d;
				event_d   = EV_OFFLINE;
				locked_d  = 1'b1;
				taps_d    = '0;
			end else if (!locked_d && taps_d == '0 && !lid_d &&
			             CMP_W'(press_d) > CMP_W'(cfg.feed_hold_ticks)) begin
				lid_d   = 1'b1;
				event_d = EV_LID_OPEN;
			end
		end else if (prev_touch_q) begin
			// A release: the press lasted one tick more than its counter shows.
			if (CMP_W'(press_inc) > CMP_W'(cfg.min_tap_ticks) &&
			    CMP_W'(press_inc) < CMP_W'(cfg.feed_hold_ticks) &&
			    !lid_d && !locked_d) begin
				if (taps_d != TAP_MAX) begin
					taps_d = taps_d + 1'b1;
				end
				since_d = '0;
			end
			if (locked_d) begin
				locked_d = 1'b0;
				taps_d   = '0;
			end
			if (lid_d) begin
				lid_d   = 1'b0;
				event_d = EV_LID_CLOSE;
			end
		end

		// Quiet gap after the last tap: evaluate and clear the pending taps.
		if (!touch && !locked_d && taps_d != '0 &&
		    CMP_W'(since_d) > CMP_W'(cfg.tap_gap_ticks)) begin
			if (taps_d == 3'd2) begin
				event_d = EV_HISTORY;
			end
			taps_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_touch_q      <= 1'b0;
			press_ticks_q     <= '0;
			since_tap_ticks_q <= '0;
			taps_seen_q       <= '0;
			tap_locked_q      <= 1'b0;
			lid_is_open_q     <= 1'b0;
			offline_mode_q    <= 1'b0;
		end else if (step) begin
			prev_touch_q      <= touch;
			press_ticks_q     <= press_d;
			since_tap_ticks_q <= since_d;
			taps_seen_q       <= taps_d;
			tap_locked_q      <= locked_d;
			lid_is_open_q     <= lid_d;
			offline_mode_q    <= offline_d;
		end
	end

	assign result.gesture_event = event_d;
	assign result.offline_flag  = offline_d;
	assign result.lid_flag      = lid_d;

	`TGD_ASSERT_SAME(a_lock_no_taps, tap_locked_q, taps_seen_q == '0, "taps pending while locked")
	`TGD_ASSERT_SAME(a_lid_no_taps, lid_is_open_q, taps_seen_q == '0, "taps pending with lid open")
	`TGD_ASSERT_SAME(a_toggle_flips, step && event_d == EV_OFFLINE, offline_d != offline_mode_q, "offline event without a mode change")

endmodule

>>> rtl/core/touch_gesture_decoder.sv
// Channel   Direction  Beat contents
// s_*       in         tdata[0] touch_level, one beat per timer tick
// m_*       out        tdata[2:0] gesture_event, [3] offline_flag, [4] lid_flag
// cfg_*     in         cfg_index selects a threshold register, cfg_data is its value
//
// Each input beat gives exactly one output beat, via the input register and then the
// output register; a new beat is taken in every cycle while the output is not stalled.
// The gesture state advances in the cycle a beat moves from the input register
// into the output register, so the rate is set by that single decision step.
// Reset (arst_n low) clears the gesture state and the valid bits of both pipeline
// registers and loads the threshold registers with their defaults; no clearing pass is needed.
// When m_tready is low the output register holds, the input register fills,
// and s_tready drops only once both are occupied.
module touch_gesture_decoder #(
	parameter int COUNTER_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [0] touch_level
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [2:0] gesture_event, [3] offline_flag,
	                                                  // [4] lid_flag
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tgd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgd_pkg::CFG_W-1:0]      cfg_data
);
	import tgd_pkg::*;
	`include "touch_gesture_decoder_macros.svh"

	// Input register: holds one touch sample until the decision step takes it.
	logic    valid_s1;
	logic    touch_s1;
	// Result register: holds one finished result until the sink takes it.
	logic    valid_s2;
	result_t result_s2;

	logic    advance;
	cfg_wr_t cfg_wr;
	cfg_t    cfg;
	result_t result_d;

	// The sample in the input register moves on whenever the result register
	// is empty or is being emptied in this cycle.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Registers may be written in any cycle; the port never stalls.
	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	tgd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_wr),
		.cfg    (cfg)
	);

	tgd_core #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.touch  (touch_s1),
		.cfg    (cfg),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			touch_s1 <= s_tdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, result_s2.lid_flag, result_s2.offline_flag,
	                   result_s2.gesture_event};

	`TGD_ASSERT_SAME(a_open_shows_lid, m_tvalid && result_s2.gesture_event == EV_LID_OPEN, result_s2.lid_flag, "lid open event with lid flag low")
	`TGD_ASSERT_SAME(a_close_shows_lid, m_tvalid && result_s2.gesture_event == EV_LID_CLOSE, !result_s2.lid_flag, "lid close event with lid flag high")
	`TGD_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(touch_s1), "input register lost a stalled sample")

endmodule
